[hw/rtl/gmw_pkg.sv]
`timescale 1ns / 1ps

package gmw_pkg;

   // queue depth must stay a power of two: the pointers wrap by overflow
   localparam int QueueDepth = 4;
   localparam int QueueAw    = $clog2(QueueDepth);

   localparam logic [7:0] Id1Byte   = 8'd31;
   localparam logic [7:0] Id2Byte   = 8'd139;
   localparam logic [7:0] CmDeflate = 8'd8;

   // FLG bit positions
   localparam int FlagHcrcBit    = 1;
   localparam int FlagExtraBit   = 2;
   localparam int FlagNameBit    = 3;
   localparam int FlagCommentBit = 4;

   localparam logic [31:0] CrcPoly = 32'hedb88320;

   typedef enum logic [1:0] {
      KIND_CMP_BYTE = 2'd0,
      KIND_DEC_BYTE = 2'd1,
      KIND_BODY_END = 2'd2,
      KIND_END_INPUT = 2'd3
   } kind_type;

   typedef enum logic [3:0] {
      PH_ID1      = 4'd0,
      PH_ID2      = 4'd1,
      PH_CM       = 4'd2,
      PH_FLG      = 4'd3,
      PH_FIXED    = 4'd4,
      PH_XLEN_LO  = 4'd5,
      PH_XLEN_HI  = 4'd6,
      PH_XTRA     = 4'd7,
      PH_NAME     = 4'd8,
      PH_COMMENT  = 4'd9,
      PH_HCRC_LO  = 4'd10,
      PH_HCRC_HI  = 4'd11,
      PH_BODY     = 4'd12,
      PH_TRAILER  = 4'd13,
      PH_DONE     = 4'd14,
      PH_ERROR    = 4'd15
   } phase_type;

   typedef enum logic [3:0] {
      ST_OK        = 4'd0,
      ST_HDR_DONE  = 4'd1,
      ST_MEMBER_OK = 4'd2,
      ST_STREAM    = 4'd3,
      ST_BAD_ID    = 4'd4,
      ST_BAD_CM    = 4'd5,
      ST_HCRC      = 4'd6,
      ST_DCRC      = 4'd7,
      ST_LEN       = 4'd8,
      ST_INCOMP    = 4'd9,
      ST_ORDER     = 4'd10
   } status_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] data;
      logic       is_id1;
      logic       is_id2;
      logic       is_cm;
      logic       is_zero;
   } item_type;

   typedef logic [31:0] crc_table_type [256];

   function automatic crc_table_type crc_table_gen();
      crc_table_type t;
      logic [31:0]   c;
      for (int i = 0; i < 256; i++) begin
         c = 32'(i);
         for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
         end
         t[i] = c;
      end
      return t;
   endfunction

   localparam crc_table_type CrcTable = crc_table_gen();

   // one byte of the reflected CRC-32, pre and post inverted
   function automatic logic [31:0] crc_update(logic [31:0] acc, logic [7:0] b);
      logic [31:0] c;
      c = ~acc;
      c = (c >> 8) ^ CrcTable[c[7:0] ^ b];
      return ~c;
   endfunction

endpackage

[hw/rtl/gmw_front.sv]
`timescale 1ns / 1ps

module gmw_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [1:0]        req_type,
   input  logic [7:0]        req_data_byte,
   output logic              q_valid,
   output gmw_pkg::item_type q_item,
   input  logic              q_pop
);

   localparam logic [gmw_pkg::QueueAw:0] Full = (gmw_pkg::QueueAw + 1)'(gmw_pkg::QueueDepth);

   gmw_pkg::item_type             mem_ff [gmw_pkg::QueueDepth];
   logic [gmw_pkg::QueueAw-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [gmw_pkg::QueueAw-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [gmw_pkg::QueueAw:0]     count_ff, count_in;
   gmw_pkg::item_type             cls;
   logic                          push;
   logic                          pop;

   always_comb begin
      cls.kind    = gmw_pkg::kind_type'(req_type);
      cls.data    = req_data_byte;
      cls.is_id1  = (req_data_byte == gmw_pkg::Id1Byte);
      cls.is_id2  = (req_data_byte == gmw_pkg::Id2Byte);
      cls.is_cm   = (req_data_byte == gmw_pkg::CmDeflate);
      cls.is_zero = (req_data_byte == 8'd0);
   end

   assign req_ready = (count_ff != Full);
   assign q_valid   = (count_ff != '0);
   assign q_item    = mem_ff[rd_ptr_ff];
   assign push      = req_valid && req_ready;
   assign pop       = q_pop && q_valid;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= cls;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= Full)
      else $error("queue count beyond depth");

   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      (count_ff != Full && count_ff != '0) |-> (wr_ptr_ff != rd_ptr_ff))
      else $error("queue pointers collide while partly full");

   a_push_count: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("push without pop did not grow the queue");

endmodule

[hw/rtl/gmw_back.sv]
`timescale 1ns / 1ps

module gmw_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   input  gmw_pkg::item_type q_item,
   output logic              q_pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic              rsp_forward_valid,
   output logic [7:0]        rsp_forward_byte,
   output logic [3:0]        rsp_status
);

   gmw_pkg::phase_type  phase_ff, phase_in;
   gmw_pkg::status_type err_ff, err_in;
   logic [7:0]          flags_ff, flags_in;
   logic [15:0]         cnt_ff, cnt_in;
   logic [31:0]         hcrc_ff, hcrc_in;
   logic [31:0]         dcrc_ff, dcrc_in;
   logic [31:0]         dcount_ff, dcount_in;
   logic [63:0]         trailer_ff, trailer_in;
   logic                rsp_valid_ff;
   logic                rsp_fwd_ff;
   logic [7:0]          rsp_byte_ff;
   gmw_pkg::status_type rsp_status_ff;

   logic                fire;
   logic                fwd;
   gmw_pkg::status_type st;
   logic                enter;
   gmw_pkg::phase_type  enter_from;
   gmw_pkg::phase_type  sec;
   logic [15:0]         cnt_inc;
   logic [63:0]         trailer_next;

   // skip header sections whose flag is clear
   function automatic gmw_pkg::phase_type next_section(gmw_pkg::phase_type p,
                                                       logic [7:0] f);
      gmw_pkg::phase_type q;
      q = p;
      if (q == gmw_pkg::PH_XLEN_LO && !f[gmw_pkg::FlagExtraBit])   q = gmw_pkg::PH_NAME;
      if (q == gmw_pkg::PH_NAME && !f[gmw_pkg::FlagNameBit])       q = gmw_pkg::PH_COMMENT;
      if (q == gmw_pkg::PH_COMMENT && !f[gmw_pkg::FlagCommentBit]) q = gmw_pkg::PH_HCRC_LO;
      if (q == gmw_pkg::PH_HCRC_LO && !f[gmw_pkg::FlagHcrcBit])    q = gmw_pkg::PH_BODY;
      return q;
   endfunction

   assign fire  = q_valid && (!rsp_valid_ff || rsp_ready);
   assign q_pop = fire;

   assign cnt_inc      = cnt_ff + 16'd1;
   assign trailer_next = {q_item.data, trailer_ff[63:8]};

   always_comb begin
      phase_in   = phase_ff;
      err_in     = err_ff;
      flags_in   = flags_ff;
      cnt_in     = cnt_ff;
      hcrc_in    = hcrc_ff;
      dcrc_in    = dcrc_ff;
      dcount_in  = dcount_ff;
      trailer_in = trailer_ff;
      fwd        = 1'b0;
      st         = gmw_pkg::ST_OK;
      enter      = 1'b0;
      enter_from = gmw_pkg::PH_NAME;
      sec        = gmw_pkg::PH_NAME;

      if (phase_ff == gmw_pkg::PH_ERROR) begin
         st = err_ff;
      end else if (phase_ff == gmw_pkg::PH_DONE) begin
         if (q_item.kind == gmw_pkg::KIND_END_INPUT) begin
            st = gmw_pkg::ST_STREAM;
         end else begin
            st = gmw_pkg::ST_ORDER;
         end
      end else begin
         case (q_item.kind)
            gmw_pkg::KIND_CMP_BYTE: begin
               if (phase_ff <= gmw_pkg::PH_COMMENT) begin
                  hcrc_in = gmw_pkg::crc_update(hcrc_ff, q_item.data);
               end
               case (phase_ff)
                  gmw_pkg::PH_ID1: begin
                     hcrc_in = gmw_pkg::crc_update('0, q_item.data);
                     if (!q_item.is_id1) st = gmw_pkg::ST_BAD_ID;
                     else phase_in = gmw_pkg::PH_ID2;
                  end
                  gmw_pkg::PH_ID2: begin
                     if (!q_item.is_id2) st = gmw_pkg::ST_BAD_ID;
                     else phase_in = gmw_pkg::PH_CM;
                  end
                  gmw_pkg::PH_CM: begin
                     if (!q_item.is_cm) st = gmw_pkg::ST_BAD_CM;
                     else phase_in = gmw_pkg::PH_FLG;
                  end
                  gmw_pkg::PH_FLG: begin
                     flags_in = q_item.data;
                     phase_in = gmw_pkg::PH_FIXED;
                     cnt_in   = '0;
                  end
                  gmw_pkg::PH_FIXED: begin
                     cnt_in = cnt_inc;
                     if (cnt_inc >= 16'd6) begin
                        enter      = 1'b1;
                        enter_from = gmw_pkg::PH_XLEN_LO;
                     end
                  end
                  gmw_pkg::PH_XLEN_LO: begin
                     cnt_in   = {8'd0, q_item.data};
                     phase_in = gmw_pkg::PH_XLEN_HI;
                  end
                  gmw_pkg::PH_XLEN_HI: begin
                     cnt_in = {q_item.data, cnt_ff[7:0]};
                     if (q_item.is_zero && cnt_ff[7:0] == 8'd0) begin
                        enter      = 1'b1;
                        enter_from = gmw_pkg::PH_NAME;
                     end else begin
                        phase_in = gmw_pkg::PH_XTRA;
                     end
                  end
                  gmw_pkg::PH_XTRA: begin
                     cnt_in = cnt_ff - 16'd1;
                     if (cnt_ff == 16'd1) begin
                        enter      = 1'b1;
                        enter_from = gmw_pkg::PH_NAME;
                     end
                  end
                  gmw_pkg::PH_NAME: begin
                     if (q_item.is_zero) begin
                        enter      = 1'b1;
                        enter_from = gmw_pkg::PH_COMMENT;
                     end
                  end
                  gmw_pkg::PH_COMMENT: begin
                     if (q_item.is_zero) begin
                        enter      = 1'b1;
                        enter_from = gmw_pkg::PH_HCRC_LO;
                     end
                  end
                  gmw_pkg::PH_HCRC_LO: begin
                     cnt_in   = {8'd0, q_item.data};
                     phase_in = gmw_pkg::PH_HCRC_HI;
                  end
                  gmw_pkg::PH_HCRC_HI: begin
                     if ({q_item.data, cnt_ff[7:0]} != hcrc_ff[15:0]) begin
                        st = gmw_pkg::ST_HCRC;
                     end else begin
                        enter      = 1'b1;
                        enter_from = gmw_pkg::PH_BODY;
                     end
                  end
                  gmw_pkg::PH_BODY: begin
                     fwd = 1'b1;
                  end
                  gmw_pkg::PH_TRAILER: begin
                     trailer_in = trailer_next;
                     cnt_in     = cnt_inc;
                     if (cnt_inc >= 16'd8) begin
                        if (trailer_next[31:0] != dcrc_ff) begin
                           st = gmw_pkg::ST_DCRC;
                        end else if (trailer_next[63:32] != dcount_ff) begin
                           st = gmw_pkg::ST_LEN;
                        end else begin
                           phase_in   = gmw_pkg::PH_ID1;
                           cnt_in     = '0;
                           trailer_in = '0;
                           st         = gmw_pkg::ST_MEMBER_OK;
                        end
                     end
                  end
                  default: begin
                     st = gmw_pkg::ST_ORDER;
                  end
               endcase
            end
            gmw_pkg::KIND_DEC_BYTE: begin
               if (phase_ff == gmw_pkg::PH_BODY) begin
                  dcrc_in   = gmw_pkg::crc_update(dcrc_ff, q_item.data);
                  dcount_in = dcount_ff + 32'd1;
               end else begin
                  st = gmw_pkg::ST_ORDER;
               end
            end
            gmw_pkg::KIND_BODY_END: begin
               if (phase_ff == gmw_pkg::PH_BODY) begin
                  phase_in   = gmw_pkg::PH_TRAILER;
                  cnt_in     = '0;
                  trailer_in = '0;
               end else begin
                  st = gmw_pkg::ST_ORDER;
               end
            end
            gmw_pkg::KIND_END_INPUT: begin
               if (phase_ff == gmw_pkg::PH_ID1) begin
                  phase_in = gmw_pkg::PH_DONE;
                  st       = gmw_pkg::ST_STREAM;
               end else begin
                  st = gmw_pkg::ST_INCOMP;
               end
            end
            default: begin
               st = gmw_pkg::ST_ORDER;
            end
         endcase

         if (enter) begin
            sec      = next_section(enter_from, flags_ff);
            phase_in = sec;
            cnt_in   = '0;
            if (sec == gmw_pkg::PH_BODY) begin
               dcrc_in   = '0;
               dcount_in = '0;
               st        = gmw_pkg::ST_HDR_DONE;
            end
         end
      end

      // any error code parks the checker; later beats repeat it
      if (phase_ff != gmw_pkg::PH_ERROR && st >= gmw_pkg::ST_BAD_ID) begin
         phase_in = gmw_pkg::PH_ERROR;
         err_in   = st;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= gmw_pkg::PH_ID1;
         err_ff     <= gmw_pkg::ST_OK;
         flags_ff   <= '0;
         cnt_ff     <= '0;
         hcrc_ff    <= '0;
         dcrc_ff    <= '0;
         dcount_ff  <= '0;
         trailer_ff <= '0;
      end else if (fire) begin
         phase_ff   <= phase_in;
         err_ff     <= err_in;
         flags_ff   <= flags_in;
         cnt_ff     <= cnt_in;
         hcrc_ff    <= hcrc_in;
         dcrc_ff    <= dcrc_in;
         dcount_ff  <= dcount_in;
         trailer_ff <= trailer_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_fwd_ff    <= fwd;
         rsp_byte_ff   <= fwd ? q_item.data : 8'd0;
         rsp_status_ff <= st;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_forward_valid = rsp_fwd_ff;
   assign rsp_forward_byte  = rsp_byte_ff;
   assign rsp_status        = rsp_status_ff;

   a_fwd_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_fwd_ff) |-> (rsp_status_ff == gmw_pkg::ST_OK))
      else $error("forwarded beat carries a non-ok status");

   a_fwd_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_fwd_ff) |-> (rsp_byte_ff == 8'd0))
      else $error("byte present on a beat that is not forwarded");

   a_error_sticky: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == gmw_pkg::PH_ERROR) |=> (phase_ff == gmw_pkg::PH_ERROR))
      else $error("left the error phase");

   a_error_entry: assert property (@(posedge clock) disable iff (reset)
      (fire && st >= gmw_pkg::ST_BAD_ID) |=>
         (phase_ff == gmw_pkg::PH_ERROR && rsp_status_ff == err_ff))
      else $error("error status without parking in the error phase");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (fire && q_item.kind == gmw_pkg::KIND_DEC_BYTE && phase_ff == gmw_pkg::PH_BODY) |=>
         (dcount_ff == $past(dcount_ff) + 32'd1))
      else $error("decoded byte not counted");

endmodule

[hw/rtl/gzip_member_wrapper_checker.sv]
`timescale 1ns / 1ps

// Walks gzip member wrappers one beat at a time and returns one result beat
// per request beat, in order. Sustained rate is one beat per clock while
// rsp_ready stays high. From request accept to result valid, the beat is
// written into the 4-entry classify queue and then carried through the
// header/trailer state machine into the result register. The limiting path is
// the table-driven CRC-32 byte update plus the phase decode in the back stage.
// Body bytes come back flagged for the inflater; decoded bytes feed the running
// CRC-32 and length that the trailer is checked against. The first error
// sticks until reset.
module gzip_member_wrapper_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_type,
   input  logic [7:0] req_data_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_forward_valid,
   output logic [7:0] rsp_forward_byte,
   output logic [3:0] rsp_status
);

   logic              q_valid;
   logic              q_pop;
   gmw_pkg::item_type q_item;

   gmw_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_type      (req_type),
      .req_data_byte (req_data_byte),
      .q_valid       (q_valid),
      .q_item        (q_item),
      .q_pop         (q_pop)
   );

   gmw_back u_back (
      .clock             (clock),
      .reset             (reset),
      .q_valid           (q_valid),
      .q_item            (q_item),
      .q_pop             (q_pop),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_forward_valid (rsp_forward_valid),
      .rsp_forward_byte  (rsp_forward_byte),
      .rsp_status        (rsp_status)
   );

endmodule
